// ===== hdl/ivc_pkg.sv =====
// ----------------------------------------------------------------------------
// ivc_pkg: shared definitions of the 3x3 window convolution filter
// Geometry limits, arithmetic widths, register indexes and the beat type
// that travels along the multiply-accumulate chain.
// ----------------------------------------------------------------------------
package ivc_pkg;

    // geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int KERNEL     = 3;
    localparam int TAPS       = KERNEL * KERNEL;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = 11;
    localparam int ROW_BITS   = 16;

    // arithmetic
    localparam int PIX_BITS  = 8;
    localparam int COEF_BITS = 16;
    localparam int ACC_BITS  = COEF_BITS + PIX_BITS + $clog2(TAPS + 1);
    localparam logic [ACC_BITS-1:0] ROUND_CONST = ACC_BITS'(1) << (COEF_BITS - 1);

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = KERNEL * COEF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ROW_TOP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ROW_MID    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ROW_BOTTOM = 3'd4;

    // reset values of the geometry registers
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd480;

    // nine window pixels, index = row * KERNEL + column, column 0 oldest
    typedef logic [TAPS-1:0][PIX_BITS-1:0] pix_vec_t;

    // one beat of the multiply-accumulate chain
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [ACC_BITS-1:0] acc;
        pix_vec_t            pix;
    } mac_beat_t;

endpackage

// ===== hdl/ivc_ram.sv =====
// ----------------------------------------------------------------------------
// ivc_ram: generic single-clock RAM
// One write port and one read port; read data is registered on read enable.
// ----------------------------------------------------------------------------
module ivc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ivc_front.sv =====
// ----------------------------------------------------------------------------
// ivc_front: raster counters, line stores and 3x3 window
// Tracks the pixel position, reads and rewrites the two line stores and
// shifts the window; flags windows that produce a filtered pixel.
// ----------------------------------------------------------------------------
module ivc_front import ivc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_fire,
    input  logic [PIX_BITS-1:0]   pixel_in,
    input  logic [WIDTH_BITS-1:0] eff_width,
    input  logic [ROW_BITS-1:0]   eff_height,
    output mac_beat_t             win_beat
);

    // position of the next pixel
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    // stage after the line store read
    logic                s1_valid_reg;
    logic [PIX_BITS-1:0] s1_pixel_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;

    // window and its result flags
    pix_vec_t window_reg, window_next;
    logic     win_valid_reg;
    logic     win_last_reg;

    logic [WIDTH_BITS-1:0]   col_ext, col_inc;
    logic [ROW_BITS:0]       row_inc;
    logic                    emit, last;
    logic [2*PIX_BITS-1:0]   rd_data;
    logic [2*PIX_BITS-1:0]   wr_data;
    logic                    wr_en;

    // window position checks
    always_comb
    begin
        col_ext = WIDTH_BITS'(col_reg);
        col_inc = col_ext + WIDTH_BITS'(1);
        row_inc = {1'b0, row_reg} + (ROW_BITS + 1)'(1);
        emit = (row_reg >= ROW_BITS'(2)) && (row_reg <= eff_height - ROW_BITS'(2)) &&
               (col_ext >= WIDTH_BITS'(2)) && (col_ext <= eff_width - WIDTH_BITS'(2));
        last = (row_reg == eff_height - ROW_BITS'(2)) &&
               (col_ext == eff_width - WIDTH_BITS'(2));
        if (col_inc >= eff_width)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, eff_height}) ? '0 : row_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: [15:8] row r-2, [7:0] row r-1
    assign wr_en   = s1_valid_reg && adv;
    assign wr_data = {rd_data[PIX_BITS-1:0], s1_pixel_reg};

    ivc_ram #(
        .WIDTH (2 * PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= pixel_in;
            s1_col_reg   <= col_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
        end
    end

    // window shift: newest column enters at column KERNEL-1
    always_comb
    begin
        for (int r = 0; r < KERNEL; r++)
        begin
            for (int c = 0; c < KERNEL - 1; c++)
            begin
                window_next[r*KERNEL+c] = window_reg[r*KERNEL+c+1];
            end
        end
        window_next[KERNEL-1]          = rd_data[2*PIX_BITS-1:PIX_BITS];
        window_next[2*KERNEL-1]        = rd_data[PIX_BITS-1:0];
        window_next[KERNEL*KERNEL-1]   = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            win_valid_reg <= 1'b0;
            win_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_valid_reg)
            begin
                window_reg <= window_next;
            end
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
            win_last_reg  <= s1_last_reg;
        end
    end

    // window beat enters the chain with the rounding offset
    always_comb
    begin
        win_beat.valid = win_valid_reg;
        win_beat.last  = win_last_reg;
        win_beat.acc   = ROUND_CONST;
        win_beat.pix   = window_reg;
    end

endmodule

// ===== hdl/ivc_mac_cell.sv =====
// ----------------------------------------------------------------------------
// ivc_mac_cell: one multiply-accumulate cell of the chain
// Adds weight times its window pixel to the running sum and hands the beat
// on to the next cell.
// ----------------------------------------------------------------------------
module ivc_mac_cell import ivc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  mac_beat_t            beat_in,
    input  logic [COEF_BITS-1:0] weight,
    input  logic [PIX_BITS-1:0]  pixel,
    output mac_beat_t            beat_out
);

    logic [COEF_BITS+PIX_BITS-1:0] product;
    logic                          valid_reg;
    logic                          last_reg;
    logic [ACC_BITS-1:0]           acc_reg;
    pix_vec_t                      pix_reg;

    assign product = weight * pixel;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= beat_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= beat_in.last;
            acc_reg  <= beat_in.acc + ACC_BITS'(product);
            pix_reg  <= beat_in.pix;
        end
    end

    always_comb
    begin
        beat_out.valid = valid_reg;
        beat_out.last  = last_reg;
        beat_out.acc   = acc_reg;
        beat_out.pix   = pix_reg;
    end

endmodule

// ===== hdl/image_window_convolution.sv =====
// ----------------------------------------------------------------------------
// image_window_convolution: 3x3 window convolution filter
// Line-buffered 3x3 weighted sum over a raster pixel stream, rounded half up
// and saturated at 255, computed by a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid/in_ready/pixel_in. For every
//   window whose top-left corner lies below row height-3 and column width-3
//   one beat leaves on out_valid/out_ready with pixel_out and frame_end;
//   frame_end marks the last filtered pixel of a frame.
//   Registers (cfg_write/cfg_index/cfg_data): 0 image_width, 1 image_height,
//   2..4 kernel rows top, middle, bottom with column 0 in the low 16 bits.
//   Write them only while no beat is in flight.
// Throughput: one pixel per cycle while the output is not stalled.
// Stages: one line store read, one window stage and nine cells, one per weight.
// Stall: the whole pipeline moves as one; when out_valid is high and
//   out_ready is low it freezes and in_ready drops. The result register is
//   the last cell, so a new pixel is taken in the cycle the result is taken.
// Reset: counters, window and pipeline valid bits clear; geometry returns
//   to 640 x 480 and all weights to zero. The line stores are not cleared.
// ----------------------------------------------------------------------------
module image_window_convolution import ivc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PIX_BITS-1:0]      pixel_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIX_BITS-1:0]      pixel_out,
    output logic                     frame_end
);

    logic [WIDTH_BITS-1:0]    width_reg;
    logic [ROW_BITS-1:0]      height_reg;
    logic [CFG_DATA_BITS-1:0] coef_reg [KERNEL];

    logic [WIDTH_BITS-1:0] eff_width;
    logic [ROW_BITS-1:0]   eff_height;
    logic                  adv;
    logic                  in_fire;
    logic                  sat;
    mac_beat_t             chain [TAPS+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            for (int k = 0; k < KERNEL; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     width_reg   <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:    height_reg  <= cfg_data[ROW_BITS-1:0];
                REG_COEF_ROW_TOP:    coef_reg[0] <= cfg_data;
                REG_COEF_ROW_MID:    coef_reg[1] <= cfg_data;
                REG_COEF_ROW_BOTTOM: coef_reg[2] <= cfg_data;
                default:             ;
            endcase
        end
    end

    // clamped geometry
    always_comb
    begin
        if (width_reg < WIDTH_BITS'(4))
        begin
            eff_width = WIDTH_BITS'(4);
        end
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            eff_width = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
        eff_height = (height_reg < ROW_BITS'(4)) ? ROW_BITS'(4) : height_reg;
    end

    // pipeline advance: the last cell is the result register
    assign adv      = !chain[TAPS].valid || out_ready;
    assign in_ready = adv;
    assign in_fire  = in_valid && adv;

    ivc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_fire    (in_fire),
        .pixel_in   (pixel_in),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .win_beat   (chain[0])
    );

    // one cell per kernel weight
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        ivc_mac_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .beat_in  (chain[k]),
            .weight   (coef_reg[k / KERNEL][(k % KERNEL) * COEF_BITS +: COEF_BITS]),
            .pixel    (chain[k].pix[k]),
            .beat_out (chain[k+1])
        );
    end

    // drop fraction and saturate
    assign sat       = |chain[TAPS].acc[ACC_BITS-1:COEF_BITS+PIX_BITS];
    assign out_valid = chain[TAPS].valid;
    assign pixel_out = sat ? '1 : chain[TAPS].acc[COEF_BITS +: PIX_BITS];
    assign frame_end = chain[TAPS].last;

endmodule

// ===== hdl/ivc_checker.sv =====
// ----------------------------------------------------------------------------
// ivc_checker: port-level checks of the convolution filter
// Watches the top-level ports for stall and reset behavior; bound to the
// top level below.
// ----------------------------------------------------------------------------
module ivc_checker import ivc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [PIX_BITS-1:0] pixel_out,
    input logic                frame_end
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_end))
    else $error("ivc: stalled result beat changed");

    // a stalled result stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("ivc: input taken while result stalled");

    // with no result waiting the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("ivc: input blocked with empty result register");

    // nothing leaves once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("ivc: result beat during reset");

endmodule

bind image_window_convolution ivc_checker u_ivc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
);
